// ===== src/fupa_pkg.sv =====
// ----------------------------------------------------------------------------
// fupa_pkg
// Shared widths and codes for the fixed unit pool allocator.
// ----------------------------------------------------------------------------
package fupa_pkg;
  localparam int OP_W     = 1;
  localparam int SLOT_W   = 3;
  localparam int UNIT_W   = 6;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 7;

  localparam logic [OP_W-1:0] OP_ALLOC   = 1'b0;
  localparam logic [OP_W-1:0] OP_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOMEM   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FOREIGN = 2'd2;

  localparam logic [CFG_W-1:0] UPB_RESET = 7'd64;
endpackage

// ===== src/fupa_if.sv =====
// ----------------------------------------------------------------------------
// fupa_in_if / fupa_out_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface fupa_in_if;
  logic                          valid;
  logic                          ready;
  logic [fupa_pkg::OP_W-1:0]     op;
  logic [fupa_pkg::SLOT_W-1:0]   release_slot;
  logic [fupa_pkg::UNIT_W-1:0]   release_unit;
  modport source (output valid, op, release_slot, release_unit, input ready);
  modport sink   (input valid, op, release_slot, release_unit, output ready);
endinterface

interface fupa_out_if;
  logic                          valid;
  logic                          ready;
  logic [fupa_pkg::STATUS_W-1:0] status;
  logic [fupa_pkg::SLOT_W-1:0]   grant_slot;
  logic [fupa_pkg::UNIT_W-1:0]   grant_unit;
  modport source (output valid, status, grant_slot, grant_unit, input ready);
  modport sink   (input valid, status, grant_slot, grant_unit, output ready);
endinterface

// ===== src/fupa_ram.sv =====
// ----------------------------------------------------------------------------
// fupa_ram
// Generic RAM, one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fupa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0]   waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0]   raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ===== src/fixed_unit_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// fixed_unit_pool_allocator
// Fixed-size unit pool over block slots with free lists and recency order.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  in_ch   | in  | op, release_slot, release_unit
//  out_ch  | out | status, grant_slot, grant_unit
//  cfg_    | in  | cfg_we, cfg_wdata (units_per_block)
//
//  One item at a time. Allocate hit: scan of the order, link RAM read, done.
//  Allocate that opens a block: scan of the live slots, open, link sweep over
//  the new block, done; failed allocate: scan, open, done. Release: scan to
//  its slot, done. Foreign release: straight to done.
//  Reset is synchronous; the link RAM needs no clearing. A stalled result
//  holds in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module fixed_unit_pool_allocator #(
  parameter int NUM_SLOTS = 8,
  parameter int MAX_UNITS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  fupa_in_if.sink                     in_ch,
  fupa_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [fupa_pkg::CFG_W-1:0]  cfg_wdata
);
  localparam int SW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW  = $clog2(NUM_SLOTS + 1);
  localparam int UW  = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
  localparam int LW  = $clog2(MAX_UNITS + 1);
  localparam int DEP = NUM_SLOTS * MAX_UNITS;
  localparam int AW  = (DEP > 1) ? $clog2(DEP) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_OPEN = 3'd2;
  localparam logic [2:0] S_POP  = 3'd3;
  localparam logic [2:0] S_INIT = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]    state_r;
  logic [fupa_pkg::CFG_W-1:0] upb_r;

  logic          live_r  [NUM_SLOTS];
  logic [LW-1:0] cnt_r   [NUM_SLOTS];
  logic [LW-1:0] ff_r    [NUM_SLOTS];
  logic [LW-1:0] size_r  [NUM_SLOTS];
  logic [SW-1:0] order_r [NUM_SLOTS];
  logic [CW-1:0] live_cnt_r;

  logic          op_r;
  logic [SW-1:0] slot_r;
  logic [UW-1:0] unit_r;
  logic [SW-1:0] idx_r;
  logic [LW-1:0] size_open_r;

  logic [fupa_pkg::STATUS_W-1:0] res_status_r;
  logic [SW-1:0] res_slot_r;
  logic [UW-1:0] res_unit_r;

  logic                          out_valid_r;
  logic [fupa_pkg::STATUS_W-1:0] out_status_r;
  logic [fupa_pkg::SLOT_W-1:0]   out_slot_r;
  logic [fupa_pkg::UNIT_W-1:0]   out_unit_r;

  // RAM ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [LW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [LW-1:0] ram_rdata;

  fupa_ram #(.WIDTH(LW), .DEPTH(DEP)) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Decode of the incoming release
  logic          in_take;
  logic [SW-1:0] in_slot;
  logic          rel_ok;
  assign in_take = in_ch.valid && in_ch.ready;
  assign in_slot = SW'(in_ch.release_slot);
  always_comb begin
    rel_ok = 1'b0;
    if (32'(in_ch.release_slot) < NUM_SLOTS && 32'(in_ch.release_unit) < MAX_UNITS) begin
      rel_ok = live_r[in_slot] && (32'(in_ch.release_unit) < 32'(size_r[in_slot]));
    end
  end

  // Scan view
  logic [SW-1:0] scan_slot;
  logic [LW-1:0] scan_ff;
  logic [UW-1:0] pop_unit;
  logic          scan_last;
  assign scan_slot = order_r[idx_r];
  assign scan_ff   = ff_r[scan_slot];
  assign pop_unit  = (32'(scan_ff) >= MAX_UNITS) ? '0 : UW'(scan_ff);
  assign scan_last = (32'(idx_r) + 1 >= 32'(live_cnt_r));

  // Empty slot search and open size
  logic          free_found;
  logic [SW-1:0] free_slot;
  logic [LW-1:0] open_size;
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
      if (!live_r[k]) begin
        free_found = 1'b1;
        free_slot  = SW'(k);
      end
    end
    open_size = (32'(upb_r) > MAX_UNITS) ? LW'(MAX_UNITS) : LW'(upb_r);
  end

  logic release_close;
  assign release_close = (32'(cnt_r[slot_r]) + 1 >= 32'(size_r[slot_r]));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(32'(slot_r) * MAX_UNITS + 32'(unit_r));
    ram_wdata = ff_r[slot_r];
    ram_raddr = AW'(32'(scan_slot) * MAX_UNITS + 32'(pop_unit));
    if (state_r == S_SCAN && op_r == fupa_pkg::OP_RELEASE && scan_slot == slot_r) begin
      ram_we = 1'b1;
    end
    if (state_r == S_INIT) begin
      ram_we    = 1'b1;
      ram_wdata = LW'(32'(unit_r) + 1);
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.grant_slot = out_slot_r;
  assign out_ch.grant_unit = out_unit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      upb_r       <= fupa_pkg::UPB_RESET;
      live_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NUM_SLOTS; k++) begin
        live_r[k] <= 1'b0;
        cnt_r[k]  <= '0;
        ff_r[k]   <= '0;
        size_r[k] <= '0;
      end
    end else begin
      if (cfg_we) begin
        upb_r <= cfg_wdata;
      end
      // the done state reloads the output register itself
      if (out_valid_r && out_ch.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_take) begin
            op_r   <= in_ch.op;
            slot_r <= in_slot;
            unit_r <= UW'(in_ch.release_unit);
            idx_r  <= '0;
            res_status_r <= fupa_pkg::ST_OK;
            res_slot_r   <= '0;
            res_unit_r   <= '0;
            if (in_ch.op == fupa_pkg::OP_RELEASE) begin
              if (rel_ok) begin
                state_r <= S_SCAN;
              end else begin
                res_status_r <= fupa_pkg::ST_FOREIGN;
                state_r      <= S_DONE;
              end
            end else begin
              state_r <= (live_cnt_r == '0) ? S_OPEN : S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (op_r == fupa_pkg::OP_ALLOC) begin
            if (cnt_r[scan_slot] != '0) begin
              res_slot_r <= scan_slot;
              res_unit_r <= pop_unit;
              slot_r     <= scan_slot;
              state_r    <= S_POP;
            end else if (scan_last) begin
              state_r <= S_OPEN;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end else if (scan_slot == slot_r) begin
            // link written by the RAM port this cycle
            if (release_close) begin
              live_r[slot_r] <= 1'b0;
              cnt_r[slot_r]  <= '0;
              ff_r[slot_r]   <= '0;
              size_r[slot_r] <= '0;
              for (int k = 0; k < NUM_SLOTS - 1; k++) begin
                if (k >= 32'(idx_r)) order_r[k] <= order_r[k+1];
              end
              live_cnt_r <= live_cnt_r - 1'b1;
            end else begin
              ff_r[slot_r]  <= LW'(unit_r);
              cnt_r[slot_r] <= cnt_r[slot_r] + 1'b1;
              for (int k = 1; k < NUM_SLOTS; k++) begin
                if (k <= 32'(idx_r)) order_r[k] <= order_r[k-1];
              end
              order_r[0] <= slot_r;
            end
            state_r <= S_DONE;
          end else if (scan_last) begin
            state_r <= S_DONE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_POP: begin
          ff_r[slot_r]  <= ram_rdata;
          cnt_r[slot_r] <= cnt_r[slot_r] - 1'b1;
          state_r       <= S_DONE;
        end
        S_OPEN: begin
          if (open_size == '0 || !free_found) begin
            res_status_r <= fupa_pkg::ST_NOMEM;
            state_r      <= S_DONE;
          end else begin
            live_r[free_slot] <= 1'b1;
            size_r[free_slot] <= open_size;
            cnt_r[free_slot]  <= open_size - 1'b1;
            ff_r[free_slot]   <= LW'(1);
            for (int k = 1; k < NUM_SLOTS; k++) begin
              order_r[k] <= order_r[k-1];
            end
            order_r[0]  <= free_slot;
            live_cnt_r  <= live_cnt_r + 1'b1;
            res_slot_r  <= free_slot;
            res_unit_r  <= '0;
            slot_r      <= free_slot;
            unit_r      <= '0;
            size_open_r <= open_size;
            state_r     <= S_INIT;
          end
        end
        S_INIT: begin
          // sweep links i -> i+1 over the new block
          if (32'(unit_r) + 1 >= 32'(size_open_r)) begin
            state_r <= S_DONE;
          end else begin
            unit_r <= unit_r + 1'b1;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_slot_r   <= fupa_pkg::SLOT_W'(res_slot_r);
            out_unit_r   <= fupa_pkg::UNIT_W'(res_unit_r);
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== tb/fupa_pool_scoreboard.sv =====
// ----------------------------------------------------------------------------
// fupa_pool_scoreboard
// Tracks the pool's slot and free-list state to predict each result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class fupa_pool_scoreboard;
  typedef struct packed {
    logic [fupa_pkg::STATUS_W-1:0] status;
    logic [fupa_pkg::SLOT_W-1:0]   slot;
    logic [fupa_pkg::UNIT_W-1:0]   unit;
  } grant_t;

  localparam int NSLOT = 8;
  localparam int NUNIT = 64;

  bit [6:0]  block_units;
  bit        live [NSLOT];
  int        free_cnt [NSLOT];
  int        first_free [NSLOT];
  int        blk_size [NSLOT];
  int        next_link [NSLOT*NUNIT];
  int        order [NSLOT];
  int        live_cnt;
  grant_t    pending [$];
  int        errors;

  function new();
    block_units = fupa_pkg::UPB_RESET;
    for (int i = 0; i < NSLOT; i++) begin
      live[i] = 0; free_cnt[i] = 0; first_free[i] = 0; blk_size[i] = 0; order[i] = 0;
    end
    foreach (next_link[i]) next_link[i] = 0;
    live_cnt = 0;
    errors = 0;
  endfunction

  function void order_drop(int pos);
    for (int i = pos; i + 1 < live_cnt; i++) order[i] = order[i+1];
    live_cnt--;
  endfunction

  function void order_to_head(int s);
    for (int i = live_cnt; i > 0; i--) order[i] = order[i-1];
    order[0] = s;
    live_cnt++;
  endfunction

  function int live_count();
    return live_cnt;
  endfunction

  function bit is_live(int s);
    return live[s];
  endfunction

  function int size_of(int s);
    return blk_size[s];
  endfunction

  function void note_request(logic op, logic [2:0] rs, logic [5:0] ru);
    grant_t g;
    bit hit;
    int s, u, sz, pos;
    g = '0;
    hit = 0;
    if (op == fupa_pkg::OP_ALLOC) begin
      for (int i = 0; i < live_cnt && !hit; i++) begin
        s = order[i];
        if (free_cnt[s] != 0) begin
          u = first_free[s];
          g.slot = 3'(s); g.unit = 6'(u);
          first_free[s] = next_link[s*NUNIT+u];
          free_cnt[s]--;
          hit = 1;
        end
      end
      if (!hit) begin
        sz = block_units > NUNIT ? NUNIT : block_units;
        s = NSLOT;
        for (int i = NSLOT - 1; i >= 0; i--) if (!live[i]) s = i;
        if (sz == 0 || s >= NSLOT) g.status = fupa_pkg::ST_NOMEM;
        else begin
          live[s] = 1; blk_size[s] = sz; free_cnt[s] = sz - 1; first_free[s] = 1;
          for (int i = 0; i < sz; i++) next_link[s*NUNIT+i] = (i + 1) & 6'h3f;
          order_to_head(s);
          g.slot = 3'(s);
        end
      end
    end else begin
      s = rs; u = ru;
      if (!live[s] || u >= blk_size[s]) g.status = fupa_pkg::ST_FOREIGN;
      else begin
        pos = 0;
        for (int i = live_cnt - 1; i >= 0; i--) if (order[i] == s) pos = i;
        next_link[s*NUNIT+u] = first_free[s];
        first_free[s] = u;
        free_cnt[s]++;
        order_drop(pos);
        if (free_cnt[s] >= blk_size[s]) begin
          live[s] = 0; free_cnt[s] = 0; first_free[s] = 0; blk_size[s] = 0;
        end else order_to_head(s);
      end
    end
    pending.push_back(g);
  endfunction

  task report(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  task check_result(logic [1:0] st, logic [2:0] gs, logic [5:0] gu);
    grant_t g;
    if (pending.size() == 0) begin
      report($sformatf("unexpected result st=%0d slot=%0d unit=%0d", st, gs, gu));
      return;
    end
    g = pending.pop_front();
    if (st !== g.status) report($sformatf("status %0d want %0d", st, g.status));
    if (gs !== g.slot) report($sformatf("grant_slot %0d want %0d", gs, g.slot));
    if (gu !== g.unit) report($sformatf("grant_unit %0d want %0d", gu, g.unit));
  endtask
endclass

// ===== tb/fixed_unit_pool_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// fixed_unit_pool_allocator_tb
// Drives allocate/release items in bursts against a stalling receiver and
// checks every result item against a tracked copy of the pool state.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module fixed_unit_pool_allocator_tb;
  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [fupa_pkg::CFG_W-1:0] cfg_wdata = '0;
  int cycles = 0;
  int stall_mode = 0;
  int burst_left = 0;
  int gap_left = 0;

  fupa_in_if  in_ch();
  fupa_out_if out_ch();
  fupa_pool_scoreboard pool;

  fixed_unit_pool_allocator dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: free-running, sparse, or heavy stalls
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      pool.check_result(out_ch.status, out_ch.grant_slot, out_ch.grant_unit);
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      default: out_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic send_item(logic op, logic [2:0] rs, logic [5:0] ru);
    if (burst_left == 0) begin
      repeat (gap_left) @(posedge clk);
      burst_left = $urandom_range(1, 12);
      gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.op <= op; in_ch.release_slot <= rs; in_ch.release_unit <= ru;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pool.note_request(op, rs, ru);
    // ready goes low after an accept
    if (burst_left == 0 && gap_left != 0) in_ch.valid <= 1'b0;
  endtask

  task automatic drain_idle();
    burst_left = 0;
    @(posedge clk);
    in_ch.valid <= 1'b0;
    while (pool.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_units(logic [6:0] v);
    drain_idle();
    cfg_we <= 1'b1; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    pool.block_units = v;
  endtask

  // release a random unit of a slot, redrawing the slot up to eight times until one is live
  task automatic random_release();
    int s, sz;
    s = $urandom_range(0, 7);
    for (int k = 0; k < 8; k++) if (!pool.is_live(s)) s = $urandom_range(0, 7);
    sz = pool.size_of(s);
    send_item(fupa_pkg::OP_RELEASE, 3'(s),
              6'(sz > 0 ? $urandom_range(0, sz - 1) : $urandom_range(0, 63)));
  endtask

  initial begin
    logic [6:0] phase_upb [6];
    pool = new();
    phase_upb = '{7'd64, 7'd3, 7'd127, 7'd1, 7'd17, 7'd2};
    in_ch.valid <= 1'b0;
    in_ch.op <= '0; in_ch.release_slot <= '0; in_ch.release_unit <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: default size, foreign releases, pool full, growth disabled
    send_item(fupa_pkg::OP_RELEASE, 3'd0, 6'd0);
    send_item(fupa_pkg::OP_ALLOC, 3'd0, 6'd0);
    send_item(fupa_pkg::OP_ALLOC, 3'd0, 6'd0);
    send_item(fupa_pkg::OP_RELEASE, 3'd0, 6'd63);
    send_item(fupa_pkg::OP_RELEASE, 3'd7, 6'd5);
    send_item(fupa_pkg::OP_RELEASE, 3'd0, 6'd1);
    send_item(fupa_pkg::OP_RELEASE, 3'd0, 6'd1);
    send_item(fupa_pkg::OP_RELEASE, 3'd0, 6'd0);
    set_units(7'd1);
    for (int i = 0; i < 9; i++) send_item(fupa_pkg::OP_ALLOC, 3'd0, 6'd0);
    send_item(fupa_pkg::OP_RELEASE, 3'd7, 6'd0);
    send_item(fupa_pkg::OP_RELEASE, 3'd3, 6'd1);
    set_units(7'd0);
    send_item(fupa_pkg::OP_ALLOC, 3'd0, 6'd0);
    send_item(fupa_pkg::OP_RELEASE, 3'd2, 6'd0);
    send_item(fupa_pkg::OP_ALLOC, 3'd0, 6'd0);

    for (int p = 0; p < 6; p++) begin
      set_units(phase_upb[p]);
      for (int n = 0; n < 100; n++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: send_item(fupa_pkg::OP_ALLOC, 3'($urandom), 6'($urandom));
          5, 6, 7, 8: random_release();
          default: send_item(fupa_pkg::OP_RELEASE, 3'($urandom), 6'($urandom));
        endcase
      end
    end

    drain_idle();
    if (pool.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
